[src/itoa_pkg.sv]
// shared types and constants for the integer to ascii formatter
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

	// conversion codes
	localparam logic [1:0] FUNC_DEC  = 2'd0;
	localparam logic [1:0] FUNC_HEXL = 2'd1;
	localparam logic [1:0] FUNC_HEXU = 2'd2;
	localparam logic [1:0] FUNC_CHAR = 2'd3;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;

	// divide by ten as multiply by ceil(2^35 / 10), then shift by 35
	localparam logic [31:0] RECIP_TEN = 32'hcccc_cccd;
	localparam int          RECIP_SHIFT = 35;

	// ten digits cover every 32-bit magnitude
	localparam int DIGIT_DEPTH = 10;
	localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] value;
	} itoa_cmd_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last;
	} itoa_result_t;

endpackage

`default_nettype wire

[src/integer_to_ascii_formatter_core.sv]
// integer to ascii formatter: decimal, hex and character conversion
//
//  channel  | signals              | transfer
//  ---------+----------------------+-------------------------------------
//  command  | start, busy, cmd     | start high while busy low
//  result   | strobe, result       | every cycle strobe is high, no stall
//
// a character conversion gives its result in the cycle after the command
// decimal: the command is loaded, ST_MUL primes the shared multiply-by-reciprocal unit, ST_DIG takes
// 1 to 10 digits through it, then ST_EMIT gives one character per cycle (up to 11)
// hex: same flow with a nibble shift per digit (up to 8 digits)
// busy drops as the last character is shown; a character conversion never raises it
// reset clears the sequencer and the strobe; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire itoa_pkg::itoa_cmd_t    cmd,
	output logic                        strobe,
	output itoa_pkg::itoa_result_t      result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIG  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam int IW = itoa_pkg::DIGIT_IDX_W;

	logic [1:0]  state_q;
	logic        dec_q;
	logic        upper_q;
	logic        neg_q;
	logic [31:0] x_q;
	logic [63:0] prod_q;
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] rd_q;
	logic [3:0]  digit_q [itoa_pkg::DIGIT_DEPTH];
	logic        strobe_q;
	itoa_pkg::itoa_result_t result_q;

	logic [31:0] quot;
	logic [31:0] quot_x10;
	logic [3:0]  digit;
	logic [31:0] next_x;
	logic [31:0] mul_a;
	logic [3:0]  rd_digit;
	logic [7:0]  rd_char;
	logic        accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// quotient and remainder of the current dividend
	assign quot     = {3'b0, prod_q[63:itoa_pkg::RECIP_SHIFT]};
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign digit    = dec_q ? (x_q[3:0] - quot_x10[3:0]) : x_q[3:0];
	assign next_x   = dec_q ? quot : (x_q >> 4);
	assign mul_a    = (state_q == ST_MUL) ? x_q : quot;

	assign rd_digit = digit_q[rd_q];
	always_comb begin
		if (rd_digit < 4'd10) begin
			rd_char = itoa_pkg::CHAR_ZERO + {4'b0, rd_digit};
		end else begin
			rd_char = (upper_q ? itoa_pkg::CHAR_UP_A : itoa_pkg::CHAR_LOW_A)
				+ {4'b0, rd_digit - 4'd10};
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= {32'b0, mul_a} * {32'b0, itoa_pkg::RECIP_TEN};
		if (state_q == ST_DIG) begin
			digit_q[cnt_q] <= digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			neg_q    <= 1'b0;
			dec_q    <= 1'b0;
			upper_q  <= 1'b0;
			x_q      <= '0;
			cnt_q    <= '0;
			rd_q     <= '0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						dec_q   <= (cmd.func == itoa_pkg::FUNC_DEC);
						upper_q <= (cmd.func == itoa_pkg::FUNC_HEXU);
						cnt_q   <= '0;
						if (cmd.func == itoa_pkg::FUNC_CHAR) begin
							strobe_q          <= 1'b1;
							result_q.char_out <= cmd.value[7:0];
							result_q.last     <= 1'b1;
						end else if (cmd.func == itoa_pkg::FUNC_DEC && cmd.value[31]) begin
							neg_q   <= 1'b1;
							x_q     <= 32'd0 - cmd.value;
							state_q <= ST_MUL;
						end else begin
							neg_q   <= 1'b0;
							x_q     <= cmd.value;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_DIG;
				end
				ST_DIG: begin
					x_q <= next_x;
					if (next_x == 32'd0) begin
						rd_q    <= cnt_q;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					if (neg_q) begin
						neg_q             <= 1'b0;
						result_q.char_out <= itoa_pkg::CHAR_MINUS;
						result_q.last     <= 1'b0;
					end else begin
						result_q.char_out <= rd_char;
						result_q.last     <= (rd_q == '0);
						if (rd_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_q <= rd_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
